// ===== design/mhe_pkg.sv =====
// ============================================================================
// mhe_pkg: shared types and constants of the min-heap extract block
// Entry layout, sizes, item modes, status codes and the controller/datapath
// command and status bundles.
// ============================================================================
package mhe_pkg;

    localparam int CAPACITY    = 64;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int CHILD_W     = ADDR_W + 2;
    localparam int KEY_W       = 31;
    localparam int TAG_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int OUT_COUNT_W = 7;

    typedef logic [KEY_W-1:0]       key_t;
    typedef logic [TAG_W-1:0]       tag_t;
    typedef logic [STATUS_W-1:0]    status_t;
    typedef logic [OUT_COUNT_W-1:0] out_count_t;
    typedef logic [COUNT_W-1:0]     count_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [CHILD_W-1:0]     child_t;

    typedef struct packed {
        key_t key;
        tag_t tag;
    } entry_t;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    localparam status_t STATUS_DONE  = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic    do_append;     // write item at the end, grow the count
        logic    do_error;      // post a flagged result, change nothing
        status_t err_code;
        logic    start_pop;     // read root and last entry
        logic    load_root;     // capture root as result, last entry moves down
        logic    write_cur;     // settle the moving entry at the current slot
        logic    sift_step;     // compare children, write winner, descend
    } mhe_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic single;           // exactly one entry held
        logic no_child;         // current slot has no children
        logic settle;           // moving entry is no larger than either child
        logic out_free;         // result register can take a new result
    } mhe_stat_t;

endpackage

// ===== design/mhe_in_if.sv =====
// ============================================================================
// mhe_in_if: item channel into the min-heap extract block
// Valid/ready handshake carrying mode, key and tag of one item.
// ============================================================================
interface mhe_in_if;
    import mhe_pkg::*;

    logic valid;
    logic ready;
    logic mode;
    key_t entry_key;
    tag_t entry_tag;

    modport source (output valid, output mode, output entry_key, output entry_tag,
                    input ready);
    modport sink   (input valid, input mode, input entry_key, input entry_tag,
                    output ready);
endinterface

// ===== design/mhe_out_if.sv =====
// ============================================================================
// mhe_out_if: result channel out of the min-heap extract block
// Valid/ready handshake carrying popped tag and key, status and entry count.
// ============================================================================
interface mhe_out_if;
    import mhe_pkg::*;

    logic       valid;
    logic       ready;
    tag_t       out_tag;
    key_t       out_key;
    status_t    status;
    out_count_t entry_count;

    modport source (output valid, output out_tag, output out_key, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input out_tag, input out_key, input status,
                    input entry_count, output ready);
endinterface

// ===== design/mhe_ram.sv =====
// ============================================================================
// mhe_ram: generic RAM, one write port and two registered read ports
// Write and reads take effect at the rising clock edge.
// ============================================================================
module mhe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

// ===== design/mhe_ctrl.sv =====
// ============================================================================
// mhe_ctrl: controller of the min-heap extract block
// Sequences append, pop, root replacement and the sift-down walk.
// ============================================================================
module mhe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_mode,
    output logic              req_ready,
    input  mhe_pkg::mhe_stat_t stat,
    output mhe_pkg::mhe_cmd_t  cmd
);
    import mhe_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_LOAD    = 4'b0010,
        ST_FETCH   = 4'b0100,
        ST_COMPARE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign req_ready = (state_reg == ST_IDLE) && stat.out_free;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_mode == MODE_APPEND)
                    begin
                        if (stat.full)
                        begin
                            cmd.do_error = 1'b1;
                            cmd.err_code = STATUS_FULL;
                        end
                        else
                        begin
                            cmd.do_append = 1'b1;
                        end
                    end
                    else if (stat.empty)
                    begin
                        cmd.do_error = 1'b1;
                        cmd.err_code = STATUS_EMPTY;
                    end
                    else
                    begin
                        cmd.start_pop = 1'b1;
                        state_next    = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load_root = 1'b1;
                state_next    = stat.single ? ST_IDLE : ST_FETCH;
            end
            ST_FETCH:
            begin
                // leaf reached: drop the moving entry here
                if (stat.no_child)
                begin
                    cmd.write_cur = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                cmd.sift_step = 1'b1;
                state_next    = stat.settle ? ST_IDLE : ST_FETCH;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

// ===== design/mhe_dpath.sv =====
// ============================================================================
// mhe_dpath: datapath of the min-heap extract block
// Heap storage, fill count, sift position, moving entry and result register.
// ============================================================================
module mhe_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  mhe_pkg::mhe_cmd_t  cmd,
    output mhe_pkg::mhe_stat_t stat,
    input  mhe_pkg::key_t      entry_key,
    input  mhe_pkg::tag_t      entry_tag,
    output logic               out_valid,
    input  logic               out_ready,
    output mhe_pkg::tag_t      out_tag,
    output mhe_pkg::key_t      out_key,
    output mhe_pkg::status_t   status,
    output mhe_pkg::out_count_t entry_count
);
    import mhe_pkg::*;

    count_t     count_reg, count_next;
    addr_t      pos_reg, pos_next;
    entry_t     cur_reg, cur_next;
    logic       out_valid_reg, out_valid_next;
    tag_t       out_tag_reg, out_tag_next;
    key_t       out_key_reg, out_key_next;
    status_t    status_reg, status_next;
    out_count_t out_count_reg, out_count_next;

    child_t left, right, count_ext;
    logic   left_ok, right_ok;
    logic   left_win, right_win;
    key_t   cand_key;

    logic   ram_we;
    addr_t  ram_waddr, ram_raddr_a, ram_raddr_b;
    entry_t ram_wdata, rd_a, rd_b;

    assign count_ext = CHILD_W'(count_reg);
    assign left      = CHILD_W'({pos_reg, 1'b1});
    assign right     = CHILD_W'({pos_reg, 1'b0}) + CHILD_W'(2);
    assign left_ok   = left < count_ext;
    assign right_ok  = right < count_ext;

    // Left child checked first, so ties stay on the left
    assign left_win  = rd_a.key < cur_reg.key;
    assign cand_key  = left_win ? rd_a.key : cur_reg.key;
    assign right_win = right_ok && (rd_b.key < cand_key);

    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == COUNT_W'(CAPACITY));
    assign stat.single   = (count_reg == COUNT_W'(1));
    assign stat.no_child = !left_ok;
    assign stat.settle   = !left_win && !right_win;
    assign stat.out_free = !out_valid_reg || out_ready;

    // Root and last entry at pop start, both children while sifting
    always_comb
    begin
        if (cmd.start_pop)
        begin
            ram_raddr_a = '0;
            ram_raddr_b = ADDR_W'(count_reg - COUNT_W'(1));
        end
        else
        begin
            ram_raddr_a = ADDR_W'(left);
            ram_raddr_b = ADDR_W'(right);
        end
    end

    always_comb
    begin
        ram_we    = cmd.do_append || cmd.write_cur || cmd.sift_step;
        ram_waddr = pos_reg;
        ram_wdata = cur_reg;
        if (cmd.do_append)
        begin
            ram_waddr = count_reg[ADDR_W-1:0];
            ram_wdata = '{key: entry_key, tag: entry_tag};
        end
        else if (cmd.sift_step)
        begin
            if (right_win)
            begin
                ram_wdata = rd_b;
            end
            else if (left_win)
            begin
                ram_wdata = rd_a;
            end
        end
    end

    mhe_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    always_comb
    begin
        count_next     = count_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_tag_next   = out_tag_reg;
        out_key_next   = out_key_reg;
        status_next    = status_reg;
        out_count_next = out_count_reg;

        if (cmd.do_append)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        if (cmd.load_root)
        begin
            count_next = count_reg - COUNT_W'(1);
            pos_next   = '0;
            cur_next   = rd_b;
        end
        if (cmd.sift_step)
        begin
            pos_next = right_win ? ADDR_W'(right) : ADDR_W'(left);
        end

        // Post one result per transaction
        if (cmd.do_append || cmd.do_error || cmd.load_root)
        begin
            out_valid_next = 1'b1;
            out_tag_next   = cmd.load_root ? rd_a.tag : '0;
            out_key_next   = cmd.load_root ? rd_a.key : '0;
            status_next    = cmd.do_error ? cmd.err_code : STATUS_DONE;
            out_count_next = OUT_COUNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        cur_reg       <= cur_next;
        out_tag_reg   <= out_tag_next;
        out_key_reg   <= out_key_next;
        status_reg    <= status_next;
        out_count_reg <= out_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_tag     = out_tag_reg;
    assign out_key     = out_key_reg;
    assign status      = status_reg;
    assign entry_count = out_count_reg;
endmodule

// ===== design/min_heap_extract.sv =====
// ============================================================================
// min_heap_extract: binary min-heap with pop and append
// Top level joining controller, datapath and heap storage.
// ============================================================================
// Usage:
//   req carries one item per transaction: mode 0 appends (key, tag) at the end
//   of the heap array without sift-up, mode 1 pops the root entry and sifts
//   down by unsigned key compare. rsp returns exactly one result per item: popped
//   tag and key (zero for appends and errors), a status code and the entry
//   count after the item. A pop on an empty heap or an append to a full heap
//   returns a status flag and leaves the heap untouched.
// Timing:
//   Appends and flagged items post their result in the cycle after acceptance.
//   A pop reads root and last entry at acceptance and posts its result from the
//   load state. The sift-down then takes per level one read of both children
//   from the dual-read RAM and one compare and write, up to five levels with 63
//   entries left. One item is in work at a time.
// Reset and stall:
//   Reset empties the heap at once; storage is not cleared. req.ready stays
//   low while a pop is loading or sifting or while an earlier result waits on rsp;
//   a stalled result holds its value until taken.
// ============================================================================
module min_heap_extract (
    input  logic clk,
    input  logic rst_n,
    mhe_in_if.sink    req,
    mhe_out_if.source rsp
);
    import mhe_pkg::*;

    mhe_cmd_t  cmd;
    mhe_stat_t stat;

    mhe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_mode  (req.mode),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mhe_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .entry_key   (req.entry_key),
        .entry_tag   (req.entry_tag),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_tag     (rsp.out_tag),
        .out_key     (rsp.out_key),
        .status      (rsp.status),
        .entry_count (rsp.entry_count)
    );

    // New items only when the result slot frees up
    assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (!rsp.valid || rsp.ready))
    else $error("item taken while a result is still blocked");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STATUS_EMPTY) |-> (rsp.entry_count == '0))
    else $error("empty-pop flag with entries held");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STATUS_FULL)
            |-> (rsp.entry_count == OUT_COUNT_W'(CAPACITY)))
    else $error("full flag below capacity");

    // A pop result never shows up in the cycle after acceptance, unless it is an empty-pop flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.mode == MODE_POP && !rsp.valid) |=> !rsp.valid
            || rsp.status == STATUS_EMPTY)
    else $error("pop result posted too early");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.status == STATUS_DONE || rsp.status == STATUS_EMPTY
                       || rsp.status == STATUS_FULL))
    else $error("undefined status code");
endmodule

// ===== test/tb_min_heap_extract.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_min_heap_extract: self-checking testbench of the min-heap extract block
// Drives append and pop items through the request channel and tracks a shadow
// heap that gives the expected tag, key, status and count of every result.
// Both sides idle at random; the receiver also holds off for a long stretch.
// ============================================================================
module tb_min_heap_extract;
    import mhe_pkg::*;

    localparam int MAX_WAIT    = 13;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 30;

    typedef struct packed {
        tag_t       tag;
        key_t       key;
        status_t    status;
        out_count_t count;
    } heap_result_t;

    logic clk = 1'b0;
    logic rst_n;

    mhe_in_if  req_if ();
    mhe_out_if rsp_if ();

    min_heap_extract u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #1 clk = ~clk;

    // Shadow copy of the heap storage and fill count
    key_t         shadow_keys [CAPACITY];
    tag_t         shadow_tags [CAPACITY];
    int           shadow_count;
    heap_result_t pending_results[$];

    int mismatch_count;
    int hold_off;
    bit no_idle;
    int idle_cycles;

    function automatic heap_result_t heap_predict(logic mode, key_t key, tag_t tag);
        heap_result_t r;
        int           pos;
        int           best;
        key_t         k;
        tag_t         t;
        r = '0;
        if (mode == MODE_APPEND)
        begin
            if (shadow_count >= CAPACITY)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                shadow_keys[shadow_count] = key;
                shadow_tags[shadow_count] = tag;
                shadow_count++;
            end
        end
        else if (shadow_count == 0)
        begin
            r.status = STATUS_EMPTY;
        end
        else
        begin
            r.tag = shadow_tags[0];
            r.key = shadow_keys[0];
            shadow_count--;
            shadow_keys[0] = shadow_keys[shadow_count];
            shadow_tags[0] = shadow_tags[shadow_count];
            pos = 0;
            forever
            begin
                best = pos;
                // left child first, so equal children resolve to the left
                for (int c = 2 * pos + 1; c <= 2 * pos + 2; c++)
                begin
                    if (c < shadow_count && shadow_keys[c] < shadow_keys[best])
                        best = c;
                end
                if (best == pos)
                    break;
                k = shadow_keys[pos];
                t = shadow_tags[pos];
                shadow_keys[pos]  = shadow_keys[best];
                shadow_tags[pos]  = shadow_tags[best];
                shadow_keys[best] = k;
                shadow_tags[best] = t;
                pos = best;
            end
        end
        r.count = out_count_t'(shadow_count);
        return r;
    endfunction

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic key_t draw_key(bit narrow);
        if (narrow)
            return key_t'($urandom_range(0, 7));
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return key_t'($urandom_range(0, 31));
            default: return key_t'($urandom);
        endcase
    endfunction

    task automatic send_item(logic mode, key_t key, tag_t tag);
        int gap;
        gap = draw_wait();
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.mode      <= mode;
        req_if.entry_key <= key;
        req_if.entry_tag <= tag;
        do @(posedge clk); while (!req_if.ready);
        pending_results.push_back(heap_predict(mode, key, tag));
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic note_mismatch(string what, heap_result_t exp_r, heap_result_t got_r);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%0t: %s: expected tag %0h key %0h status %0d count %0d,",
                      " got tag %0h key %0h status %0d count %0d"},
                     $realtime, what, exp_r.tag, exp_r.key, exp_r.status, exp_r.count,
                     got_r.tag, got_r.key, got_r.status, got_r.count);
    endtask

    always @(posedge clk)
    begin : result_check
        heap_result_t exp_r;
        heap_result_t got_r;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got_r = '{rsp_if.out_tag, rsp_if.out_key, rsp_if.status, rsp_if.entry_count};
            if (pending_results.size() == 0)
            begin
                note_mismatch("unexpected result", '0, got_r);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got_r.tag !== exp_r.tag || got_r.key !== exp_r.key ||
                    got_r.status !== exp_r.status || got_r.count !== exp_r.count)
                    note_mismatch("result mismatch", exp_r, got_r);
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait();
            while (stall > 0 || hold_off > 0)
            begin
                @(negedge clk);
                rsp_if.ready <= 1'b0;
                if (hold_off > 0)
                    hold_off--;
                else
                    stall--;
            end
            @(negedge clk);
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic test_empty_pop();
        send_item(MODE_POP, '0, '0);
        send_item(MODE_POP, '1, '1);
        drain_results();
    endtask

    // Appends have no sift-up, so the first entry stays at the root
    task automatic test_append_pop_extremes();
        send_item(MODE_APPEND, '1, '1);
        send_item(MODE_APPEND, '0, '0);
        send_item(MODE_APPEND, '1, '0);
        send_item(MODE_APPEND, '0, '1);
        repeat (5) send_item(MODE_POP, '0, '0);
        drain_results();
    endtask

    task automatic test_equal_children();
        send_item(MODE_APPEND, key_t'(1), tag_t'(8'h01));
        send_item(MODE_APPEND, key_t'(3), tag_t'(8'h0a));
        send_item(MODE_APPEND, key_t'(3), tag_t'(8'h0b));
        send_item(MODE_APPEND, key_t'(9), tag_t'(8'h09));
        repeat (4) send_item(MODE_POP, '0, '0);
        drain_results();
    endtask

    // Child equal to the moving entry must not swap
    task automatic test_equal_keys_hold();
        send_item(MODE_APPEND, key_t'(5), tag_t'(8'h51));
        send_item(MODE_APPEND, key_t'(5), tag_t'(8'h52));
        send_item(MODE_APPEND, key_t'(5), tag_t'(8'h53));
        repeat (3) send_item(MODE_POP, '0, '0);
        drain_results();
    endtask

    task automatic test_fill_and_drain(bit narrow);
        while (shadow_count < CAPACITY)
            send_item(MODE_APPEND, draw_key(narrow), tag_t'($urandom));
        repeat (3) send_item(MODE_APPEND, draw_key(narrow), tag_t'($urandom));
        while (shadow_count > 0)
            send_item(MODE_POP, draw_key(0), tag_t'($urandom));
        repeat (2) send_item(MODE_POP, draw_key(0), tag_t'($urandom));
        drain_results();
    endtask

    task automatic test_backpressure();
        hold_off = HOLD_CYCLES;
        no_idle  = 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            if (i % 3 == 2)
                send_item(MODE_POP, draw_key(0), tag_t'($urandom));
            else
                send_item(MODE_APPEND, draw_key(0), tag_t'($urandom));
        end
        no_idle = 1'b0;
        drain_results();
    endtask

    task automatic test_random_mix(int n_items);
        int append_pct;
        bit narrow;
        append_pct = 50;
        narrow     = 1'b0;
        for (int i = 0; i < n_items; i++)
        begin
            // new traffic profile every fifty items
            if (i % 50 == 0)
            begin
                case ($urandom_range(0, 4))
                    0:       append_pct = 90;
                    1:       append_pct = 65;
                    2:       append_pct = 50;
                    3:       append_pct = 35;
                    default: append_pct = 10;
                endcase
                no_idle = ($urandom_range(0, 3) == 0);
                narrow  = ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(1, 100) <= append_pct)
                send_item(MODE_APPEND, draw_key(narrow), tag_t'($urandom));
            else
                send_item(MODE_POP, draw_key(0), tag_t'($urandom));
        end
        no_idle = 1'b0;
        drain_results();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        req_if.valid     = 1'b0;
        req_if.mode      = MODE_APPEND;
        req_if.entry_key = '0;
        req_if.entry_tag = '0;
        rsp_if.ready     = 1'b0;
        shadow_count     = 0;
        mismatch_count   = 0;
        hold_off         = 0;
        no_idle          = 1'b0;
        idle_cycles      = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_pop();
        test_append_pop_extremes();
        test_equal_children();
        test_equal_keys_hold();
        test_fill_and_drain(1'b0);
        test_backpressure();
        test_fill_and_drain(1'b1);
        test_random_mix(600);

        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
